### sv/ate_pkg.sv
package ate_pkg;

  // Field widths of the request and result channels.
  localparam int KIND_W   = 3;
  localparam int POS_W    = 7;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 7;

  // Operation codes carried by a request.
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_READ   = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_SEARCH = 3'd4,
    KIND_SORT   = 3'd5
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_INS,
    S_INS_WR,
    S_DEL,
    S_DEL_WR,
    S_SRCH,
    S_SRCH_CMP,
    S_SORT_I,
    S_SORT_A,
    S_SORT_J,
    S_SORT_CMP,
    S_DONE
  } state_t;

endpackage

### sv/ate_channels.sv
// Request channel: operation, position and value.
interface ate_in_if import ate_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  item_position;
  logic signed [WORD_W-1:0] item_value;

  modport source (output valid, output kind, output item_position, output item_value,
                  input ready);
  modport sink   (input valid, input kind, input item_position, input item_value,
                  output ready);
endinterface

// Result channel: status, search hit, read word and count.
interface ate_out_if import ate_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FOUND_W-1:0]  found_position;
  logic signed [WORD_W-1:0] read_value;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output found_position, output read_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_position, input read_value,
                  input entry_count, output ready);
endinterface

### sv/ate_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module ate_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/array_table_engine.sv
// Clear, unused kinds and refused requests go straight to the result; a read waits for the
// registered RAM data. Search, insert, delete and sort step through the store word by word,
// each word step a RAM read followed by a compare or a write. One request at a time: a new
// request is taken only after the last result has moved to the output register, where it
// waits while the next request is taken. Reset (synchronous, rst_n low) empties the store;
// the RAM contents are not cleared and need no clearing pass.
module array_table_engine import ate_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ate_in_if.sink     in_ch,
  ate_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > POS_W) ? CW : POS_W;

  // Control state.
  state_t  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic    out_valid_r, out_valid_nxt;

  // Working registers.
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  status_t           st_r, st_nxt;
  logic [FOUND_W-1:0] found_r, found_nxt;
  logic [WORD_W-1:0] rdv_r, rdv_nxt;

  // Output registers.
  status_t            o_status_r, o_status_nxt;
  logic [FOUND_W-1:0] o_found_r, o_found_nxt;
  logic [WORD_W-1:0]  o_rdv_r, o_rdv_nxt;
  logic [COUNT_W-1:0] o_count_r, o_count_nxt;

  // RAM port signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Shared compare unit and cursor steppers.
  logic [WORD_W-1:0] cmp_a;
  logic              cmp_eq;
  logic              cmp_gt;
  logic [LW-1:0]     pos_ext;
  logic [LW-1:0]     cnt_ext;
  logic [CW-1:0]     i_inc;
  logic [CW-1:0]     j_inc;

  ate_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One comparator serves both the search match and the sort exchange test.
  assign cmp_a   = (state_r == S_SORT_CMP) ? acc_r : val_r;
  assign cmp_eq  = (cmp_a == ram_rdata);
  assign cmp_gt  = ($signed(cmp_a) > $signed(ram_rdata));
  assign pos_ext = LW'(in_ch.item_position);
  assign cnt_ext = LW'(cnt_r);
  assign i_inc   = i_r + CW'(1);
  assign j_inc   = j_r + CW'(1);

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = o_status_r;
  assign out_ch.found_position = o_found_r;
  assign out_ch.read_value     = o_rdv_r;
  assign out_ch.entry_count    = o_count_r;

  // Sequencer: next state, RAM accesses and result capture.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    st_nxt        = st_r;
    found_nxt     = found_r;
    rdv_nxt       = rdv_r;
    o_status_nxt  = o_status_r;
    o_found_nxt   = o_found_r;
    o_rdv_nxt     = o_rdv_r;
    o_count_nxt   = o_count_r;
    ram_we        = 1'b0;
    ram_waddr     = i_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = i_r[AW-1:0];

    // The output register empties when the consumer takes the result.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          st_nxt    = ST_OK;
          found_nxt = '0;
          rdv_nxt   = '0;
          val_nxt   = in_ch.item_value;
          pos_nxt   = CW'(in_ch.item_position);
          state_nxt = S_DONE;
          case (kind_t'(in_ch.kind))
            KIND_CLEAR: begin
              cnt_nxt = '0;
            end
            KIND_READ: begin
              if (pos_ext < cnt_ext) begin
                ram_raddr = pos_ext[AW-1:0];
                state_nxt = S_RD_WAIT;
              end else begin
                st_nxt = ST_BAD;
              end
            end
            KIND_INSERT: begin
              if (pos_ext > cnt_ext || cnt_ext >= LW'(DEPTH)) begin
                st_nxt = ST_BAD;
              end else begin
                i_nxt     = cnt_r;
                state_nxt = S_INS;
              end
            end
            KIND_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                st_nxt = ST_BAD;
              end else begin
                i_nxt     = CW'(in_ch.item_position);
                state_nxt = S_DEL;
              end
            end
            KIND_SEARCH: begin
              i_nxt     = '0;
              state_nxt = S_SRCH;
            end
            KIND_SORT: begin
              i_nxt     = '0;
              state_nxt = S_SORT_I;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        rdv_nxt   = ram_rdata;
        state_nxt = S_DONE;
      end

      // Insert: move words up from the top, then drop the value in.
      S_INS: begin
        if (i_r > pos_r) begin
          ram_raddr = i_r[AW-1:0] - AW'(1);
          state_nxt = S_INS_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[AW-1:0];
          ram_wdata = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        i_nxt     = i_r - CW'(1);
        state_nxt = S_INS;
      end

      // Delete: move the later words down one place.
      S_DEL: begin
        if (i_inc < cnt_r) begin
          ram_raddr = i_inc[AW-1:0];
          state_nxt = S_DEL_WR;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        i_nxt     = i_inc;
        state_nxt = S_DEL;
      end

      // Search: probe held words in order until the first match.
      S_SRCH: begin
        if (i_r < cnt_r) begin
          ram_raddr = i_r[AW-1:0];
          state_nxt = S_SRCH_CMP;
        end else begin
          st_nxt    = ST_MISS;
          state_nxt = S_DONE;
        end
      end
      S_SRCH_CMP: begin
        if (cmp_eq) begin
          st_nxt    = ST_OK;
          found_nxt = FOUND_W'(i_r);
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_SRCH;
        end
      end

      // Sort: hold the word at i, exchange it with every smaller later word,
      // and write it back when the inner pass ends.
      S_SORT_I: begin
        if (i_inc < cnt_r) begin
          ram_raddr = i_r[AW-1:0];
          state_nxt = S_SORT_A;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SORT_A: begin
        acc_nxt   = ram_rdata;
        j_nxt     = i_inc;
        state_nxt = S_SORT_J;
      end
      S_SORT_J: begin
        if (j_r < cnt_r) begin
          ram_raddr = j_r[AW-1:0];
          state_nxt = S_SORT_CMP;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = i_r[AW-1:0];
          ram_wdata = acc_r;
          i_nxt     = i_inc;
          state_nxt = S_SORT_I;
        end
      end
      S_SORT_CMP: begin
        if (cmp_gt) begin
          ram_we    = 1'b1;
          ram_waddr = j_r[AW-1:0];
          ram_wdata = acc_r;
          acc_nxt   = ram_rdata;
        end
        j_nxt     = j_inc;
        state_nxt = S_SORT_J;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          o_status_nxt  = st_r;
          o_found_nxt   = found_r;
          o_rdv_nxt     = rdv_r;
          o_count_nxt   = COUNT_W'(cnt_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    val_r      <= val_nxt;
    acc_r      <= acc_nxt;
    st_r       <= st_nxt;
    found_r    <= found_nxt;
    rdv_r      <= rdv_nxt;
    o_status_r <= o_status_nxt;
    o_found_r  <= o_found_nxt;
    o_rdv_r    <= o_rdv_nxt;
    o_count_r  <= o_count_nxt;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import ate_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 700;
  localparam int SETTLE_CYCLES = 200;

  // Kinds the block does not decode; they must leave the table alone.
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [FOUND_W-1:0]       found;
    logic signed [WORD_W-1:0] word;
    logic [COUNT_W-1:0]       count;
  } res_t;

  logic clk;
  logic rst_n;

  ate_in_if  in_ch ();
  ate_out_if out_ch ();

  array_table_engine #(.DEPTH(TABLE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the table, updated when a request is accepted.
  logic signed [WORD_W-1:0] shadow_words [TABLE_DEPTH];
  int unsigned shadow_count;

  req_t req_backlog [$];
  res_t due_results [$];
  req_t on_bus;
  res_t oldest_due;
  int   send_gap;
  int   hold_left;
  int   mismatches;
  int   sent_items;
  bit   paused_once;

  // Clock: 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  // Apply one accepted request to the shadow table and queue the result it must give.
  task automatic table_apply(input req_t r);
    res_t o;
    int unsigned p;
    int unsigned i;
    int unsigned j;
    logic signed [WORD_W-1:0] t;
    o = '0;
    o.status = ST_OK;
    p = r.position;
    case (r.kind)
      KIND_CLEAR: begin
        shadow_count = 0;
      end
      KIND_READ: begin
        if (p < shadow_count) o.word = shadow_words[p];
        else o.status = ST_BAD;
      end
      KIND_INSERT: begin
        if (p > shadow_count || shadow_count >= TABLE_DEPTH) begin
          o.status = ST_BAD;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = r.value;
          shadow_count++;
        end
      end
      KIND_DELETE: begin
        if (p >= shadow_count) begin
          o.status = ST_BAD;
        end else begin
          for (i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      KIND_SEARCH: begin
        o.status = ST_MISS;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_words[i] == r.value) begin
            o.status = ST_OK;
            o.found = i[FOUND_W-1:0];
            break;
          end
        end
      end
      KIND_SORT: begin
        // Exchange sort: each later word smaller than the one at i is swapped in.
        for (i = 0; i + 1 < shadow_count; i++) begin
          for (j = i + 1; j < shadow_count; j++) begin
            if (shadow_words[i] > shadow_words[j]) begin
              t = shadow_words[i];
              shadow_words[i] = shadow_words[j];
              shadow_words[j] = t;
            end
          end
        end
      end
      default: begin
      end
    endcase
    o.count = shadow_count[COUNT_W-1:0];
    due_results.push_back(o);
  endtask

  // Request driver: takes the next request from the backlog once the last one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      shadow_count = 0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) table_apply(on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          on_bus = req_backlog.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.kind          <= on_bus.kind;
          in_ch.item_position <= on_bus.position;
          in_ch.item_value    <= on_bus.value;
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, and each result checked against the oldest due one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with no request outstanding", out_ch.status, 0);
        end else begin
          oldest_due = due_results.pop_front();
          if (out_ch.status !== oldest_due.status)
            report_mismatch("status", out_ch.status, oldest_due.status);
          if (out_ch.found_position !== oldest_due.found)
            report_mismatch("found_position", out_ch.found_position, oldest_due.found);
          if (out_ch.read_value !== oldest_due.word)
            report_mismatch("read_value", out_ch.read_value, oldest_due.word);
          if (out_ch.entry_count !== oldest_due.count)
            report_mismatch("entry_count", out_ch.entry_count, oldest_due.count);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold_left = pick_gap();
      end
    end
  end

  // Queue one request; at most one waits behind the one on the bus.
  task automatic send(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                      input logic [WORD_W-1:0] value);
    req_t r;
    while (req_backlog.size() != 0) @(negedge clk);
    r.kind = kind;
    r.position = pos;
    r.value = value;
    req_backlog.push_back(r);
    if (kind != KIND_SPARE6 && kind != KIND_SPARE7) sent_items++;
  endtask

  // Hold the sender until every request is taken and every result has come back.
  task automatic drain();
    while (req_backlog.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // Values lean toward extremes and a few small numbers so that duplicates occur.
  function automatic logic [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r < 5) return WORD_W'($urandom_range(0, 6) - 3);
    return $urandom;
  endfunction

  // A value the table most likely holds, so that searches hit.
  function automatic logic [WORD_W-1:0] held_value();
    if (shadow_count == 0) return pick_value();
    return shadow_words[$urandom_range(0, shadow_count - 1)];
  endfunction

  // Mostly a held position, sometimes anything up to the top of the field.
  function automatic logic [POS_W-1:0] held_position();
    int unsigned c;
    c = shadow_count;
    if (c > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, c - 1);
    return $urandom_range(c, 127);
  endfunction

  task automatic random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      send(KIND_READ, held_position(), $urandom);
    end else if (r < 42) begin
      if ($urandom_range(0, 4) != 0) send(KIND_INSERT, $urandom_range(0, shadow_count),
                                          pick_value());
      else send(KIND_INSERT, $urandom_range(0, 127), pick_value());
    end else if (r < 60) begin
      send(KIND_DELETE, held_position(), $urandom);
    end else if (r < 82) begin
      if ($urandom_range(0, 3) != 0) send(KIND_SEARCH, $urandom_range(0, 127), held_value());
      else send(KIND_SEARCH, $urandom_range(0, 127), pick_value());
    end else if (r < 88) begin
      send(KIND_SORT, $urandom_range(0, 127), $urandom);
    end else if (r < 92) begin
      send(KIND_CLEAR, $urandom_range(0, 127), $urandom);
    end else if (r < 96) begin
      send($urandom_range(0, 1) ? KIND_SPARE7 : KIND_SPARE6, $urandom_range(0, 127), $urandom);
    end else begin
      send($urandom_range(0, 7), $urandom_range(0, 127), $urandom);
    end
  endtask

  // One episode: load the table to a target size, then a run of mixed requests.
  task automatic run_episode();
    int goal;
    int k;
    int ops;
    if ($urandom_range(0, 9) == 0) goal = TABLE_DEPTH;
    else goal = $urandom_range(1, 12);
    if ($urandom_range(0, 3) != 0) send(KIND_CLEAR, $urandom_range(0, 127), $urandom);
    k = 0;
    while (shadow_count < goal && k < TABLE_DEPTH + 16) begin
      if ($urandom_range(0, 2) == 0) send(KIND_INSERT, $urandom_range(0, shadow_count),
                                          pick_value());
      else send(KIND_INSERT, shadow_count, pick_value());
      k++;
    end
    // A full table: inserts must be refused, the top entry still readable.
    if (goal == TABLE_DEPTH) begin
      send(KIND_INSERT, $urandom_range(0, TABLE_DEPTH), pick_value());
      send(KIND_READ, TABLE_DEPTH - 1, $urandom);
      send(KIND_READ, TABLE_DEPTH, $urandom);
      send(KIND_SEARCH, $urandom_range(0, 127), held_value());
    end
    ops = $urandom_range(10, 30);
    for (k = 0; k < ops; k++) random_op();
  endtask

  // Main sequence: reset, directed requests, random episodes, then the verdict.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.item_position = '0;
    in_ch.item_value = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    sent_items = 0;
    paused_once = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) shadow_words[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table: everything positional is refused and searches miss.
    send(KIND_CLEAR, 127, 32'hFFFF_FFFF);
    send(KIND_READ, 0, 0);
    send(KIND_DELETE, 0, 0);
    send(KIND_SEARCH, 0, 0);
    send(KIND_INSERT, 1, 5);
    // Load extremes, including an insert at the end and one in the middle.
    send(KIND_INSERT, 0, 32'h7FFF_FFFF);
    send(KIND_INSERT, 1, 32'h8000_0000);
    send(KIND_INSERT, 0, 0);
    send(KIND_INSERT, 3, 32'hFFFF_FFFF);
    send(KIND_INSERT, 2, 0);
    send(KIND_INSERT, 6, 7);
    send(KIND_READ, 4, 0);
    send(KIND_READ, 5, 0);
    send(KIND_READ, 127, 0);
    // Searches: a hit, the first of two equal words, and a miss.
    send(KIND_SEARCH, 127, 32'h8000_0000);
    send(KIND_SEARCH, 0, 0);
    send(KIND_SEARCH, 0, 32'h1234_5678);
    // Sort with signed extremes and equal words, then check both ends.
    send(KIND_SORT, 0, 0);
    send(KIND_READ, 0, 0);
    send(KIND_READ, 4, 0);
    send(KIND_DELETE, 127, 0);
    send(KIND_DELETE, 0, 0);
    send(KIND_DELETE, 3, 0);
    send(KIND_SPARE6, 127, 32'hFFFF_FFFF);
    send(KIND_SPARE7, 0, 0);
    send(KIND_CLEAR, 0, 0);
    send(KIND_READ, 0, 0);
    drain();

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      run_episode();
      if (!paused_once && sent_items >= RANDOM_ITEMS / 2) begin
        drain();
        paused_once = 1'b1;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #180_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
